// ===== rtl/core/ppid_pkg.sv =====
// Shared types, constants and helper for the positional PID block.
// Holds the item structs, configuration struct and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppid_pkg;

    // fraction bits of the Q-format gains
    localparam int GAIN_FRAC_BITS = 8;

    // internal arithmetic widths
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int PPROD_W = 16 + ERR_W;
    localparam int DPROD_W = 16 + DIFF_W;
    localparam int SUM_W   = 35;

    typedef struct packed {
        logic signed [15:0] measured;
        logic signed [15:0] target;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               gated;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic [30:0]        integral_limit;
        logic [30:0]        output_limit;
        logic [15:0]        error_gate;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4,
        REG_ERROR_GATE     = 3'd5
    } cfg_reg_t;

    // symmetric clamp of a signed value to +-lim
    function automatic logic signed [SUM_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] x,
        input logic [30:0]             lim
    );
        logic signed [SUM_W-1:0] lim_s;
        lim_s = $signed({{(SUM_W-31){1'b0}}, lim});
        if (x > lim_s)
            return lim_s;
        else if (x < -lim_s)
            return -lim_s;
        else
            return x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppid_cfg.sv =====
// Configuration register file of the positional PID block.
// Depends on ppid_pkg for the configuration struct and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module ppid_cfg
    import ppid_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the register index, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:      cfg_next.prop_gain      = $signed(cfg_data[15:0]);
                REG_INTEG_GAIN:     cfg_next.integ_gain     = $signed(cfg_data[15:0]);
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = $signed(cfg_data[15:0]);
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data;
                REG_OUTPUT_LIMIT:   cfg_next.output_limit   = cfg_data;
                REG_ERROR_GATE:     cfg_next.error_gate     = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ppid_core.sv =====
// PID arithmetic and controller state (integral and previous error).
// Depends on ppid_pkg for item and configuration types and clamp helper.
`timescale 1ns / 1ps
`default_nettype none

module ppid_core
    import ppid_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire in_item_t item,
    input  wire logic     step,
    output out_item_t     result
);

    logic signed [31:0]       integral_acc_reg;
    logic signed [31:0]       integral_acc_next;
    logic signed [ERR_W-1:0]  prev_error_reg;
    logic signed [ERR_W-1:0]  prev_error_next;

    logic signed [ERR_W-1:0]   err;
    logic [ERR_W-1:0]          mag;
    logic                      gate_hit;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PPROD_W-1:0] p_prod;
    logic signed [PPROD_W-1:0] i_prod;
    logic signed [DPROD_W-1:0] d_prod;
    logic signed [PPROD_W-1:0] p_sh;
    logic signed [PPROD_W-1:0] i_sh;
    logic signed [DPROD_W-1:0] d_sh;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [SUM_W-1:0]   acc_clamped;
    logic signed [SUM_W-1:0]   total;
    logic signed [SUM_W-1:0]   total_clamped;

    // error and gate check
    assign err      = $signed({item.target[15], item.target})
                    - $signed({item.measured[15], item.measured});
    assign mag      = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign gate_hit = (cfg.error_gate != '0) && (mag > {1'b0, cfg.error_gate});
    assign diff     = $signed({err[ERR_W-1], err})
                    - $signed({prev_error_reg[ERR_W-1], prev_error_reg});

    // gain products with floor shift
    assign p_prod = PPROD_W'(cfg.prop_gain) * PPROD_W'(err);
    assign i_prod = PPROD_W'(cfg.integ_gain) * PPROD_W'(err);
    assign d_prod = DPROD_W'(cfg.deriv_gain) * DPROD_W'(diff);
    assign p_sh   = p_prod >>> GAIN_FRAC_BITS;
    assign i_sh   = i_prod >>> GAIN_FRAC_BITS;
    assign d_sh   = d_prod >>> GAIN_FRAC_BITS;

    // integral update and output sum, each clamped
    assign acc_sum       = SUM_W'(integral_acc_reg) + SUM_W'(i_sh);
    assign acc_clamped   = clamp_sym(acc_sum, cfg.integral_limit);
    assign total         = SUM_W'(p_sh) + acc_clamped + SUM_W'(d_sh);
    assign total_clamped = clamp_sym(total, cfg.output_limit);

    // result item
    always_comb
    begin
        if (gate_hit)
        begin
            result.drive = '0;
            result.gated = 1'b1;
        end
        else
        begin
            result.drive = total_clamped[31:0];
            result.gated = 1'b0;
        end
    end

    // state moves only on an ungated step
    always_comb
    begin
        integral_acc_next = integral_acc_reg;
        prev_error_next   = prev_error_reg;
        if (step && !gate_hit)
        begin
            integral_acc_next = acc_clamped[31:0];
            prev_error_next   = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_acc_reg <= '0;
            prev_error_reg   <= '0;
        end
        else
        begin
            integral_acc_reg <= integral_acc_next;
            prev_error_reg   <= prev_error_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/positional_pid_with_clamps.sv =====
// Positional PID controller with integral clamp, output clamp and error gate.
// Top level: input register, output register and handshake control.
// Depends on ppid_pkg, ppid_cfg and ppid_core.
//
// Usage:
//   in channel  (in_valid/in_ready/in_item): one measured/target pair per item.
//   out channel (out_valid/out_ready/out_item): one drive/gated result per item.
//   cfg port: cfg_wr_en with cfg_index and cfg_data writes one register per
//   cycle; write only while no item is in flight.
// Path: an accepted item waits in the input register; the core computes its
//   result combinationally into the output register, which drives out_valid.
// Throughput: one item per cycle while out_ready stays high; the integral and
//   previous-error state moves on the edge that loads the output register.
// Stall: when out_ready is low the output register holds its item; the input
//   register still takes one more item, after which in_ready drops until the
//   output is taken.
// Reset: rst_n clears all gains, limits, the gate, the integral, the previous
//   error and both valid flags; in_ready is high once the input flag is clear.
`timescale 1ns / 1ps
`default_nettype none

module positional_pid_with_clamps
    import ppid_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item
);

    cfg_t      cfg;
    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    in_item_t  in_item_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    out_item_t result;
    logic      advance;
    logic      in_take;

    ppid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppid_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_item_reg),
        .step   (advance),
        .result (result)
    );

    // handshake control
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // next values of both stages
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance)
            in_valid_next = 1'b0;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_item_next  = in_item;
        end
        if (out_ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_item_next  = result;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for positional_pid_with_clamps: directed corner items, then random
// phases under several idle/stall mixes, checked against an in-bench PID predictor.
// Depends on ppid_pkg and the positional_pid_with_clamps RTL.
`timescale 1ns / 1ps

module tb_top;
    import ppid_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PRESSURE_ITEMS  = 150;
    localparam logic [30:0] LIMIT_MAX = 31'h7fff_ffff;
    // indexes past the last register, writes there must be dropped
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;

    // register shadow and controller state for prediction
    cfg_t      reg_shadow = '0;
    longint    integ_acc  = 0;
    longint    prev_err_est = 0;
    in_item_t  pending_items[$];
    out_item_t expected_results[$];

    // traffic shaping
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic out_hold       = 1'b0;
    event hold_kick;
    bit   in_fire        = 1'b0;

    // bookkeeping
    int cycle_cnt       = 0;
    int err_cnt         = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int gated_seen      = 0;
    int stall_cycles    = 0;
    int phase_cnt       = 0;

    positional_pid_with_clamps dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // symmetric saturation to +-lim
    function automatic longint limit_sym(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // next drive for a sample; if ungated, updates the integral and last error
    function automatic out_item_t compute_drive(input in_item_t sample);
        longint    err;
        longint    mag;
        longint    p_term;
        longint    d_term;
        longint    total;
        out_item_t res;
        err = longint'($signed(sample.target)) - longint'($signed(sample.measured));
        mag = (err < 0) ? -err : err;
        res.drive = '0;
        res.gated = 1'b1;
        // gate trips only on a strictly larger magnitude, state untouched
        if (reg_shadow.error_gate != 0 && mag > longint'(reg_shadow.error_gate))
            return res;
        p_term = (longint'($signed(reg_shadow.prop_gain)) * err) >>> GAIN_FRAC_BITS;
        integ_acc = limit_sym(integ_acc
                              + ((longint'($signed(reg_shadow.integ_gain)) * err)
                                 >>> GAIN_FRAC_BITS),
                              longint'(reg_shadow.integral_limit));
        d_term = (longint'($signed(reg_shadow.deriv_gain)) * (err - prev_err_est))
                 >>> GAIN_FRAC_BITS;
        total = limit_sym(p_term + integ_acc + d_term, longint'(reg_shadow.output_limit));
        prev_err_est = err;
        res.drive = total[31:0];
        res.gated = 1'b0;
        return res;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [30:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return 31'd0;
            1: return LIMIT_MAX;
            2: return 31'($urandom_range(1, 1000));
            3: return 31'($urandom_range(1, 200000));
            default: return 31'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_gate();
        case ($urandom_range(0, 5))
            0, 1: return 16'd0;
            2: return 16'($urandom_range(1, 64));
            3: return 16'($urandom_range(1, 2000));
            4: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    // one register write, issued at the falling edge
    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PROP_GAIN:      reg_shadow.prop_gain      = val[15:0];
            REG_INTEG_GAIN:     reg_shadow.integ_gain     = val[15:0];
            REG_DERIV_GAIN:     reg_shadow.deriv_gain     = val[15:0];
            REG_INTEGRAL_LIMIT: reg_shadow.integral_limit = val;
            REG_OUTPUT_LIMIT:   reg_shadow.output_limit   = val;
            REG_ERROR_GATE:     reg_shadow.error_gate     = val[15:0];
            default: ;
        endcase
    endtask

    // drop the write enable and return on a rising edge
    task automatic finish_writes();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // full register set; upper data bits of narrow registers carry junk
    task automatic load_config(input logic [15:0] p_gain, input logic [15:0] i_gain,
                               input logic [15:0] d_gain, input logic [30:0] i_lim,
                               input logic [30:0] o_lim, input logic [15:0] gate);
        write_reg(REG_PROP_GAIN, {15'($urandom()), p_gain});
        write_reg(REG_INTEG_GAIN, {15'($urandom()), i_gain});
        write_reg(REG_DERIV_GAIN, {15'($urandom()), d_gain});
        write_reg(REG_INTEGRAL_LIMIT, i_lim);
        write_reg(REG_OUTPUT_LIMIT, o_lim);
        write_reg(REG_ERROR_GATE, {15'($urandom()), gate});
        finish_writes();
        phase_cnt++;
    endtask

    task automatic queue_item(input int meas, input int tgt);
        in_item_t it;
        it.measured = 16'(meas);
        it.target   = 16'(tgt);
        pending_items.push_back(it);
    endtask

    // wait until every queued item went through and its result came back
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        while ((pending_items.size() != 0 || in_valid || expected_results.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            err_cnt++;
            expected_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random config, then mostly near-setpoint samples around the gate
    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int span;
        int meas;
        int tgt;
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 31'($urandom()));
        load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                    pick_gate());
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        span = (reg_shadow.error_gate != 0) ? int'(reg_shadow.error_gate) + 2 : 400;
        repeat (ITEMS_PER_PHASE)
        begin
            tgt = int'($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    meas = tgt - (int'($urandom_range(0, 2 * span)) - span);
                    if (meas > 32767)
                        meas = 32767;
                    if (meas < -32768)
                        meas = -32768;
                end
                6: meas = $urandom_range(0, 1) ? -32768 : 32767;
                default: meas = int'($urandom_range(0, 65535)) - 32768;
            endcase
            queue_item(meas, tgt);
        end
        drain_and_settle();
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        out_ready <= !out_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // long receiver hold-off to back the block up
    always @(hold_kick)
    begin
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold = 1'b0;
    end

    // monitor: check results, predict accepted items
    always @(posedge clk)
    begin
        out_item_t want;
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                $error("result with no item pending: drive %0d gated %0b",
                       out_item.drive, out_item.gated);
                err_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.drive !== want.drive)
                begin
                    $error("drive: expected %0d, got %0d", want.drive, out_item.drive);
                    err_cnt++;
                end
                if (out_item.gated !== want.gated)
                begin
                    $error("gated: expected %0b, got %0b", want.gated, out_item.gated);
                    err_cnt++;
                end
                if (want.gated)
                    gated_seen++;
            end
        end
        if (rst_n && in_valid && !in_ready)
            stall_cycles++;
        if (in_fire)
        begin
            expected_results.push_back(compute_drive(in_item));
            items_accepted++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int idle_modes[4];
        int stall_modes[4];
        idle_modes  = '{0, 74, 0, 26};
        stall_modes = '{0, 0, 74, 26};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // full-scale gains, open limits, extreme errors
        load_config(16'h7fff, 16'h8000, 16'h7fff, LIMIT_MAX, LIMIT_MAX, 16'd0);
        queue_item(-32768, 32767);
        queue_item(32767, -32768);
        queue_item(0, 0);
        queue_item(-1, -1);
        queue_item(32767, 32767);
        drain_and_settle();

        // gate of 100: equal magnitude passes, one more is gated
        load_config(16'd256, 16'h7fff, 16'hff80, 31'd500, 31'd2000, 16'd100);
        queue_item(0, 100);
        queue_item(50, -50);
        queue_item(-1, 100);
        queue_item(1, -100);
        queue_item(-32768, 32767);
        queue_item(10, 90);
        queue_item(0, 0);
        drain_and_settle();

        // spare indexes ignored; integral limit dropped under the held integral,
        // output limit of zero, widest gate
        write_reg(REG_SPARE_6, LIMIT_MAX);
        write_reg(REG_SPARE_7, 31'h5555_5555);
        load_config(16'h8000, 16'd0, 16'h7fff, 31'd30, 31'd0, 16'hffff);
        queue_item(0, 10);
        queue_item(-32768, 32767);
        queue_item(32767, -32768);
        queue_item(5, 5);
        drain_and_settle();

        // gate of one, integral limit of zero
        load_config(16'hff00, 16'h0100, 16'h8000, 31'd0, LIMIT_MAX, 16'd1);
        queue_item(0, 1);
        queue_item(1, 0);
        queue_item(0, 2);
        queue_item(3, 3);
        drain_and_settle();

        // random phases over every idle/stall mix
        for (int rep = 0; rep < 2; rep++)
        begin
            for (int k = 0; k < 4; k++)
                run_random_phase(idle_modes[k], stall_modes[k]);
        end

        // back-pressure: sender at full rate while the receiver holds off
        load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                    16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (PRESSURE_ITEMS)
            queue_item(int'($urandom_range(0, 65535)) - 32768,
                       int'($urandom_range(0, 65535)) - 32768);
        -> hold_kick;
        drain_and_settle();

        repeat (10) @(posedge clk);
        $display("summary: %0d items in, %0d results checked (%0d gated), %0d config sets",
                 items_accepted, results_checked, gated_seen, phase_cnt);
        $display("summary: input held back for %0d cycles, %0d failures",
                 stall_cycles, err_cnt);
        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
